@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the waypoint follower RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wpf_pkg.sv @@
// ----------------------------------------------------------------------------
// wpf_pkg
// Constants, codes and types shared by the waypoint follower modules.
// ----------------------------------------------------------------------------
package wpf_pkg;

  // Parameter defaults
  localparam int DEF_MAX_WAYPOINTS = 64;
  localparam int DEF_COORD_WIDTH   = 32;

  // Field widths
  localparam int DATA_W    = 32;  // coordinate and command fields
  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 6;
  localparam int GAIN_W    = 16;
  localparam int SPEED_W   = 31;
  localparam int TOL_W     = 31;
  localparam int TOTAL_W   = 7;
  localparam int IDX_OUT_W = 6;

  // Gain is Q4.12
  localparam int GAIN_SHIFT = 12;

  // Stream widths
  localparam int S_TDATA_W = 200;  // 198 bits of fields, padded to bytes
  localparam int S_TUSER_W = REQ_W;
  localparam int M_TDATA_W = 104;  // 102 bits of fields, padded to bytes
  localparam int M_TUSER_W = 2;

  // APB
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [1:0]       reg_idx_t;

  localparam req_t REQ_LOAD    = 2'd0;
  localparam req_t REQ_POS     = 2'd1;
  localparam req_t REQ_RESTART = 2'd2;

  localparam reg_idx_t REG_GAIN  = 2'd0;
  localparam reg_idx_t REG_SPEED = 2'd1;
  localparam reg_idx_t REG_TOL   = 2'd2;
  localparam reg_idx_t REG_TOTAL = 2'd3;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd2458;   // about 0.6
  localparam logic [SPEED_W-1:0] SPEED_RST = 31'd65536;  // 1.0
  localparam logic [TOL_W-1:0]   TOL_RST   = 31'd6554;   // about 0.10
  localparam logic [TOTAL_W-1:0] TOTAL_RST = 7'd0;

endpackage

@@ hdl/waypoint_follower_unit.sv @@
// ----------------------------------------------------------------------------
// waypoint_follower_unit
// Proportional waypoint follower: table of 3D waypoints, per-position velocity
// commands toward the current target, and advance on arrival.
// ----------------------------------------------------------------------------
// Timing: a position beat lands in the input register (with its table read)
//   when it is accepted; its command then moves on into the output register,
//   which drives m_tvalid.
// Throughput: one beat per cycle; the input holds only while the output
//   register is full and not taken.
// Reset (rst, synchronous): registers return to their defaults, the target
//   index goes to 0, both registers empty. The waypoint table is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waypoint_follower_unit #(
  parameter int MAX_WAYPOINTS = wpf_pkg::DEF_MAX_WAYPOINTS,
  parameter int COORD_WIDTH   = wpf_pkg::DEF_COORD_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wpf_pkg::APB_AW-1:0]     paddr,
  input  logic [wpf_pkg::APB_DW-1:0]     pwdata,
  output logic [wpf_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  // Slave side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // load_index[5:0], load_x, load_y, load_z, pos_x, pos_y, pos_alt, zero pad
  input  logic [wpf_pkg::S_TDATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  logic [wpf_pkg::S_TUSER_W-1:0]  s_tuser,
  // Master side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // cmd_vx, cmd_vy, cmd_alt, target_index[5:0], zero pad
  output logic [wpf_pkg::M_TDATA_W-1:0]  m_tdata,
  // arrived, all_done
  output logic [wpf_pkg::M_TUSER_W-1:0]  m_tuser
);
  import wpf_pkg::*;

  // Table index width, coordinate storage width and comparison widths
  localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CW = (IW + 1 > TOTAL_W) ? IW + 1 : TOTAL_W;
  localparam int LW = (IW + 1 > SLOT_W) ? IW + 1 : SLOT_W;
  localparam int SW = (COORD_WIDTH < DATA_W) ? COORD_WIDTH : DATA_W;
  localparam int EW = (SW + 2 > TOL_W + 2) ? SW + 2 : TOL_W + 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  position_gain;
  logic [SPEED_W-1:0] max_speed;
  logic [TOL_W-1:0]   arrive_tolerance;
  logic [TOTAL_W-1:0] waypoint_total;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      position_gain    <= GAIN_RST;
      max_speed        <= SPEED_RST;
      arrive_tolerance <= TOL_RST;
      waypoint_total   <= TOTAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN:  position_gain    <= pwdata[GAIN_W-1:0];
        REG_SPEED: max_speed        <= pwdata[SPEED_W-1:0];
        REG_TOL:   arrive_tolerance <= pwdata[TOL_W-1:0];
        REG_TOTAL: waypoint_total   <= pwdata[TOTAL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN:  prdata = APB_DW'(position_gain);
      REG_SPEED: prdata = APB_DW'(max_speed);
      REG_TOL:   prdata = APB_DW'(arrive_tolerance);
      REG_TOTAL: prdata = APB_DW'(waypoint_total);
    endcase
  end

  // --------------------------------------------------------------------------
  // Input unpacking and global advance
  // --------------------------------------------------------------------------
  logic [SLOT_W-1:0] in_slot;
  logic [SW-1:0]     in_lx, in_ly, in_lz, in_px, in_py, in_pz;
  req_t              in_req;
  logic              adv;
  logic              accept;

  assign in_req  = s_tuser;
  assign in_slot = s_tdata[5:0];
  assign in_lx   = s_tdata[6 +: SW];
  assign in_ly   = s_tdata[38 +: SW];
  assign in_lz   = s_tdata[70 +: SW];
  assign in_px   = s_tdata[102 +: SW];
  assign in_py   = s_tdata[134 +: SW];
  assign in_pz   = s_tdata[166 +: SW];

  // Both registers move when the output register is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  // Total in use, capped at table depth
  logic [CW-1:0] total_ext;
  logic [CW-1:0] tot;
  logic          tot_nz;

  assign total_ext = CW'(waypoint_total);
  assign tot       = (total_ext > CW'(MAX_WAYPOINTS)) ? CW'(MAX_WAYPOINTS) : total_ext;
  assign tot_nz    = (tot != '0);

  // --------------------------------------------------------------------------
  // Waypoint table: written on accept of a load, read on every accept at the
  // target index the item will see
  // --------------------------------------------------------------------------
  logic [3*SW-1:0] wp_mem [MAX_WAYPOINTS];
  logic [3*SW-1:0] rd_wp;
  logic [LW-1:0]   slot_ext;
  logic            slot_ok;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   ct;
  logic [IW-1:0]   ct_next;
  logic [CW-1:0]   ct_next_ext;

  assign slot_ext = LW'(in_slot);
  assign slot_ok  = (slot_ext < LW'(MAX_WAYPOINTS));

  // Clamp the next target to the last waypoint in use
  assign ct_next_ext = CW'(ct_next);
  always_comb begin
    if (ct_next_ext >= tot && tot_nz) begin
      rd_addr = IW'(tot - CW'(1));
    end else begin
      rd_addr = ct_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req == REQ_LOAD && slot_ok) begin
      wp_mem[slot_ext[IW-1:0]] <= {in_lz, in_ly, in_lx};
    end
    if (accept) begin
      rd_wp <= wp_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Input register: accepted beat beside its table entry
  // --------------------------------------------------------------------------
  logic          s1_valid;
  req_t          s1_req;
  logic [IW-1:0] s1_idx;
  logic [SW-1:0] s1_px, s1_py, s1_pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= in_req;
      s1_idx <= rd_addr;
      s1_px  <= in_px;
      s1_py  <= in_py;
      s1_pz  <= in_pz;
    end
  end

  // --------------------------------------------------------------------------
  // Errors, arrival test and target update
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] wp_x, wp_y, wp_z;
  logic signed [SW:0]   ex, ey, ez;
  logic signed [EW-1:0] ex_w, ey_w, ez_w, tol_p, tol_n;
  logic                 s1_res;
  logic                 s1_arr;
  logic                 s1_last;
  logic                 s1_done;
  logic                 s1_restart;
  logic                 s1_step;
  logic [CW-1:0]        idx_inc;

  assign wp_x = rd_wp[0 +: SW];
  assign wp_y = rd_wp[SW +: SW];
  assign wp_z = rd_wp[2*SW +: SW];

  assign ex = {wp_x[SW-1], wp_x} - {s1_px[SW-1], s1_px};
  assign ey = {wp_y[SW-1], wp_y} - {s1_py[SW-1], s1_py};
  assign ez = {wp_z[SW-1], wp_z} - {s1_pz[SW-1], s1_pz};

  // |e| < tol on each axis as a pair of signed compares
  assign ex_w  = EW'(ex);
  assign ey_w  = EW'(ey);
  assign ez_w  = EW'(ez);
  assign tol_p = EW'(arrive_tolerance);
  assign tol_n = -tol_p;

  assign s1_arr = (ex_w < tol_p) && (ex_w > tol_n) &&
                  (ey_w < tol_p) && (ey_w > tol_n) &&
                  (ez_w < tol_p) && (ez_w > tol_n);

  // Empty table gives no result and leaves the target alone
  assign s1_res     = s1_valid && s1_req == REQ_POS && tot_nz;
  assign idx_inc    = CW'(s1_idx) + CW'(1);
  assign s1_last    = (idx_inc >= tot);
  assign s1_done    = s1_arr && s1_last;
  assign s1_restart = s1_valid && s1_req == REQ_RESTART;
  assign s1_step    = s1_res && s1_arr && !s1_last;

  always_comb begin
    priority if (s1_restart) begin
      ct_next = '0;
    end else if (s1_step) begin
      ct_next = idx_inc[IW-1:0];
    end else if (s1_res) begin
      ct_next = s1_idx;
    end else begin
      ct_next = ct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ct <= '0;
    end else if (adv) begin
      ct <= ct_next;
    end
  end

  // --------------------------------------------------------------------------
  // Gain, saturation and rescale on the live errors
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] vel_x, vel_y;

  wpf_vel #(
    .ERR_W (SW + 1)
  ) u_vel_x (
    .err       (ex),
    .gain      (position_gain),
    .max_speed (max_speed),
    .vel       (vel_x)
  );

  wpf_vel #(
    .ERR_W (SW + 1)
  ) u_vel_y (
    .err       (ey),
    .gain      (position_gain),
    .max_speed (max_speed),
    .vel       (vel_y)
  );

  // --------------------------------------------------------------------------
  // Output register: saturated velocities and status
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] out_vx, out_vy, out_alt;
  logic [IDX_OUT_W-1:0]     out_idx;
  logic                     out_arr, out_done;
  logic [IW+IDX_OUT_W-1:0]  s1_idx_ext;

  assign s1_idx_ext = (IW + IDX_OUT_W)'(s1_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vx   <= vel_x;
      out_vy   <= vel_y;
      out_alt  <= DATA_W'(wp_z);
      out_idx  <= s1_idx_ext[IDX_OUT_W-1:0];
      out_arr  <= s1_arr;
      out_done <= s1_done;
    end
  end

  assign m_tdata = {{(M_TDATA_W - 3*DATA_W - IDX_OUT_W){1'b0}},
                    out_idx, out_alt, out_vy, out_vx};
  assign m_tuser = {out_done, out_arr};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `WPF_ASSERT_NOW(a_done_arrived, clk, rst, m_tvalid && m_tuser[1], m_tuser[0], "stray done")
  `WPF_ASSERT_NOW(a_hold_full, clk, rst, m_tvalid && !m_tready, !s_tready, "input on stall")
  `WPF_ASSERT_NEXT(a_restart_clears, clk, rst, adv && s1_restart, ct == '0, "target kept")
  `WPF_ASSERT_NEXT(a_advance, clk, rst, adv && s1_step, ct == $past(s1_idx) + IW'(1), "no advance")
  `WPF_ASSERT_NEXT(a_result_out, clk, rst, adv && s1_res, m_tvalid, "command dropped")

endmodule

@@ hdl/wpf_vel.sv @@
// ----------------------------------------------------------------------------
// wpf_vel
// Gain multiply, saturation and Q4.12 rescale in one combinational pass.
// ----------------------------------------------------------------------------
module wpf_vel #(
  parameter int ERR_W = wpf_pkg::DEF_COORD_WIDTH + 1
) (
  input  logic signed [ERR_W-1:0]           err,
  input  logic        [wpf_pkg::GAIN_W-1:0] gain,
  input  logic        [wpf_pkg::SPEED_W-1:0] max_speed,
  output logic signed [wpf_pkg::DATA_W-1:0] vel
);
  import wpf_pkg::*;

  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int SAT_W  = (PROD_W > SPEED_W + GAIN_SHIFT + 1) ? PROD_W
                                                              : SPEED_W + GAIN_SHIFT + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [SAT_W-1:0]  prod_w;
  logic signed [SAT_W-1:0]  lim_p;
  logic signed [SAT_W-1:0]  lim_n;
  logic signed [SAT_W-1:0]  sat;

  assign prod = err * $signed({1'b0, gain});

  always_comb begin
    prod_w = SAT_W'(prod);
    lim_p  = SAT_W'({max_speed, {GAIN_SHIFT{1'b0}}});
    lim_n  = -lim_p;
    priority if (prod_w > lim_p) begin
      sat = lim_p;
    end else if (prod_w < lim_n) begin
      sat = lim_n;
    end else begin
      sat = prod_w;
    end
  end

  // Dropping the fraction bits of a two's complement value rounds toward -inf
  assign vel = sat[GAIN_SHIFT +: DATA_W];

endmodule
